/* hdl/dfls_pkg.sv */
// Shared types, character codes and transition tables for the literal scanner.
`default_nettype none

package dfls_pkg;

  // Default widths handed to the top-level parameters
  localparam int ACC_BITS_DFLT   = 32;
  localparam int COUNT_BITS_DFLT = 8;

  // Width of the max_width register and of the character counter
  localparam int WIDTH_BITS = 8;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  // Scanner states, one-hot
  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_SIGNED = 8'b0000_0010,
    ST_INT    = 8'b0000_0100,
    ST_DOT    = 8'b0000_1000,
    ST_DIGDOT = 8'b0001_0000,
    ST_EMARK  = 8'b0010_0000,
    ST_ESIGN  = 8'b0100_0000,
    ST_EXPDIG = 8'b1000_0000
  } state_t;

  // Character classes
  typedef enum logic [2:0] {
    CLS_DIG,
    CLS_DOT,
    CLS_EXP,
    CLS_SGN,
    CLS_OTHER
  } cls_t;

  // Transition actions
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SIGN,
    ACT_ESIGN,
    ACT_INT,
    ACT_FRAC,
    ACT_EXP,
    ACT_QUIT
  } act_t;

  typedef struct packed {
    act_t   act;
    state_t nxt;
  } trans_t;

  // Control part of the scan state
  typedef struct packed {
    state_t state;
    logic   sign;
    logic   exp_sign;
    logic   sat;
  } scan_ctl_t;

  localparam scan_ctl_t SCAN_CTL_CLEAR = '{state: ST_INIT, sign: 1'b0, exp_sign: 1'b0,
                                           sat: 1'b0};

  // Single-bit fields of one result
  typedef struct packed {
    logic is_valid;
    logic char_taken;
    logic mantissa_negative;
    logic exp_negative;
    logic overflowed;
  } res_flags_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t cls;
    unique case (c) inside
      [CH_ZERO:CH_NINE]: cls = CLS_DIG;
      CH_DOT:            cls = CLS_DOT;
      CH_PLUS, CH_MINUS: cls = CLS_SGN;
      CH_LOW_E, CH_UP_E: cls = CLS_EXP;
      default:           cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // States that hold a complete number
  function automatic logic state_has_digits(input state_t st);
    return (st == ST_INT) || (st == ST_DIGDOT) || (st == ST_EXPDIG);
  endfunction

  // Action and next state for a class in a state
  function automatic trans_t lookup(input cls_t cls, input state_t st);
    trans_t t;
    t = '{act: ACT_QUIT, nxt: ST_INIT};
    unique case (cls)
      CLS_DIG: begin
        unique case (st) inside
          ST_INIT, ST_SIGNED, ST_INT:     t = '{act: ACT_INT,  nxt: ST_INT};
          ST_DOT, ST_DIGDOT:              t = '{act: ACT_FRAC, nxt: ST_DIGDOT};
          ST_EMARK, ST_ESIGN, ST_EXPDIG:  t = '{act: ACT_EXP,  nxt: ST_EXPDIG};
          default:                        t = '{act: ACT_QUIT, nxt: ST_INIT};
        endcase
      end
      CLS_DOT: begin
        unique case (st) inside
          ST_INIT, ST_SIGNED: t = '{act: ACT_NONE, nxt: ST_DOT};
          ST_INT:             t = '{act: ACT_NONE, nxt: ST_DIGDOT};
          default:            t = '{act: ACT_QUIT, nxt: ST_INIT};
        endcase
      end
      CLS_EXP: begin
        unique case (st) inside
          ST_INT, ST_DIGDOT: t = '{act: ACT_NONE, nxt: ST_EMARK};
          default:           t = '{act: ACT_QUIT, nxt: ST_INIT};
        endcase
      end
      CLS_SGN: begin
        unique case (st) inside
          ST_INIT:  t = '{act: ACT_SIGN,  nxt: ST_SIGNED};
          ST_EMARK: t = '{act: ACT_ESIGN, nxt: ST_ESIGN};
          default:  t = '{act: ACT_QUIT,  nxt: ST_INIT};
        endcase
      end
      default: t = '{act: ACT_QUIT, nxt: ST_INIT};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* hdl/dfls_if.sv */
// Valid/ready channel interfaces for characters in and scan results out.
`default_nettype none

interface dfls_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface dfls_result_if import dfls_pkg::*; #(
  parameter int ACC_BITS   = ACC_BITS_DFLT,
  parameter int COUNT_BITS = COUNT_BITS_DFLT
);
  logic                  valid;
  logic                  ready;
  logic                  is_valid;
  logic                  char_taken;
  logic                  mantissa_negative;
  logic [ACC_BITS-1:0]   int_part;
  logic [ACC_BITS-1:0]   frac_digits;
  logic [COUNT_BITS-1:0] frac_len;
  logic [ACC_BITS-1:0]   exp_value;
  logic                  exp_negative;
  logic                  overflowed;

  modport source (output valid, is_valid, char_taken, mantissa_negative, int_part,
                  frac_digits, frac_len, exp_value, exp_negative, overflowed,
                  input ready);
  modport sink (input valid, is_valid, char_taken, mantissa_negative, int_part,
                frac_digits, frac_len, exp_value, exp_negative, overflowed,
                output ready);
endinterface

`default_nettype wire

/* hdl/dfls_mac10.sv */
// Saturating multiply-by-ten-and-add-digit unit shared by the accumulators.
`default_nettype none

module dfls_mac10 import dfls_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DFLT
) (
  input  wire logic [ACC_BITS-1:0] acc,
  input  wire logic [3:0]          digit,
  output logic      [ACC_BITS-1:0] result,
  output logic                     ovf
);

  localparam int SUM_BITS = ACC_BITS + 4;

  logic [SUM_BITS-1:0] acc_ext;
  logic [SUM_BITS-1:0] sum;

  // acc*10 as acc*8 + acc*2, then the digit
  assign acc_ext = {4'b0000, acc};
  assign sum     = (acc_ext << 3) + (acc_ext << 1) + {{(SUM_BITS-4){1'b0}}, digit};

  // Anything above the accumulator width means it would pass its maximum
  assign ovf    = |sum[SUM_BITS-1:ACC_BITS];
  assign result = ovf ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];

endmodule

`default_nettype wire

/* hdl/dfls_step.sv */
// One scanner step: classify the character, look up the transition, update state.
`default_nettype none

module dfls_step import dfls_pkg::*; #(
  parameter int ACC_BITS   = ACC_BITS_DFLT,
  parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
  input  wire logic [WIDTH_BITS-1:0] max_width,
  input  wire logic [7:0]            char_code,
  input  wire logic                  end_of_input,
  input  wire scan_ctl_t             ctl,
  input  wire logic [ACC_BITS-1:0]   int_acc,
  input  wire logic [ACC_BITS-1:0]   frac_acc,
  input  wire logic [ACC_BITS-1:0]   exp_acc,
  input  wire logic [COUNT_BITS-1:0] frac_count,
  input  wire logic [WIDTH_BITS-1:0] char_count,
  output scan_ctl_t                  ctl_next,
  output logic      [ACC_BITS-1:0]   int_acc_next,
  output logic      [ACC_BITS-1:0]   frac_acc_next,
  output logic      [ACC_BITS-1:0]   exp_acc_next,
  output logic      [COUNT_BITS-1:0] frac_count_next,
  output logic      [WIDTH_BITS-1:0] char_count_next,
  output logic                       emit,
  output res_flags_t                 res_flags,
  output logic      [ACC_BITS-1:0]   res_int,
  output logic      [ACC_BITS-1:0]   res_frac,
  output logic      [COUNT_BITS-1:0] res_flen,
  output logic      [ACC_BITS-1:0]   res_exp
);

  cls_t                  cls;
  trans_t                tr;
  logic                  is_end;
  logic                  skip;
  logic                  term;
  logic                  take;
  logic                  width_hit;
  logic [3:0]            digit;
  logic [ACC_BITS-1:0]   mac_in;
  logic [ACC_BITS-1:0]   mac_out;
  logic                  mac_ovf;
  logic                  acc_act;
  logic                  fcnt_full;
  scan_ctl_t             upd_ctl;
  logic [ACC_BITS-1:0]   upd_int;
  logic [ACC_BITS-1:0]   upd_frac;
  logic [ACC_BITS-1:0]   upd_exp;
  logic [COUNT_BITS-1:0] upd_fcnt;
  logic [WIDTH_BITS-1:0] upd_ccnt;

  // Decode
  assign cls    = classify(char_code);
  assign tr     = lookup(cls, ctl.state);
  assign digit  = 4'(char_code - CH_ZERO);
  assign is_end = end_of_input || (char_code == CH_NUL);

  // Leading whitespace is dropped without a result
  assign skip = !is_end && (ctl.state == ST_INIT) && (char_count == '0) &&
                is_space(char_code);
  assign term = !skip && (is_end || (cls == CLS_OTHER) || (tr.act == ACT_QUIT));
  assign take = !skip && !term;

  // Shared multiply-by-ten for whichever accumulator the action names
  always_comb begin
    case (tr.act)
      ACT_FRAC: mac_in = frac_acc;
      ACT_EXP:  mac_in = exp_acc;
      default:  mac_in = int_acc;
    endcase
  end

  dfls_mac10 #(.ACC_BITS(ACC_BITS)) u_mac10 (
    .acc    (mac_in),
    .digit  (digit),
    .result (mac_out),
    .ovf    (mac_ovf)
  );

  assign acc_act   = (tr.act == ACT_INT) || (tr.act == ACT_FRAC) || (tr.act == ACT_EXP);
  assign fcnt_full = (frac_count == {COUNT_BITS{1'b1}});

  // State after taking the character
  always_comb begin
    upd_ctl       = ctl;
    upd_ctl.state = tr.nxt;
    if (tr.act == ACT_SIGN) begin
      upd_ctl.sign = (char_code == CH_MINUS);
    end
    if (tr.act == ACT_ESIGN) begin
      upd_ctl.exp_sign = (char_code == CH_MINUS);
    end
    upd_ctl.sat = ctl.sat || (acc_act && mac_ovf) || ((tr.act == ACT_FRAC) && fcnt_full);
    upd_int  = (tr.act == ACT_INT)  ? mac_out : int_acc;
    upd_frac = (tr.act == ACT_FRAC) ? mac_out : frac_acc;
    upd_exp  = (tr.act == ACT_EXP)  ? mac_out : exp_acc;
    upd_fcnt = ((tr.act == ACT_FRAC) && !fcnt_full) ? frac_count + 1'b1 : frac_count;
    upd_ccnt = (char_count == {WIDTH_BITS{1'b1}}) ? char_count : char_count + 1'b1;
  end

  // Width limit ends the number on the character that reaches it
  assign width_hit = take && (max_width != '0) && (upd_ccnt >= max_width);
  assign emit      = term || width_hit;

  // Result comes from the updated state on a width hit, else from the current one
  always_comb begin
    if (width_hit) begin
      res_flags.is_valid          = state_has_digits(upd_ctl.state);
      res_flags.mantissa_negative = upd_ctl.sign;
      res_flags.exp_negative      = upd_ctl.exp_sign;
      res_flags.overflowed        = upd_ctl.sat;
      res_int  = upd_int;
      res_frac = upd_frac;
      res_flen = upd_fcnt;
      res_exp  = upd_exp;
    end else begin
      res_flags.is_valid          = state_has_digits(ctl.state);
      res_flags.mantissa_negative = ctl.sign;
      res_flags.exp_negative      = ctl.exp_sign;
      res_flags.overflowed        = ctl.sat;
      res_int  = int_acc;
      res_frac = frac_acc;
      res_flen = frac_count;
      res_exp  = exp_acc;
    end
    res_flags.char_taken = width_hit;
  end

  // Next scan state: cleared after a result, held on a skipped blank
  always_comb begin
    if (emit) begin
      ctl_next        = SCAN_CTL_CLEAR;
      int_acc_next    = '0;
      frac_acc_next   = '0;
      exp_acc_next    = '0;
      frac_count_next = '0;
      char_count_next = '0;
    end else if (take) begin
      ctl_next        = upd_ctl;
      int_acc_next    = upd_int;
      frac_acc_next   = upd_frac;
      exp_acc_next    = upd_exp;
      frac_count_next = upd_fcnt;
      char_count_next = upd_ccnt;
    end else begin
      ctl_next        = ctl;
      int_acc_next    = int_acc;
      frac_acc_next   = frac_acc;
      exp_acc_next    = exp_acc;
      frac_count_next = frac_count;
      char_count_next = char_count;
    end
  end

endmodule

`default_nettype wire

/* hdl/decimal_float_literal_scanner.sv */
// Top level: input register, scan state registers and result register.
// Throughput: one character per cycle unless a result is due while the result slot stalls;
//   each character passes the step logic (table lookup and one multiply-by-ten-add) once,
//   between the input register and the state registers; results go on to the result register.
// The input side keeps taking characters while a result waits, unless a second result is due.
// Reset (rst, synchronous): scan state cleared to the initial state, max_width to zero,
//   no result pending.
`default_nettype none

module decimal_float_literal_scanner import dfls_pkg::*; #(
  parameter int ACC_BITS   = ACC_BITS_DFLT,
  parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [WIDTH_BITS-1:0] cfg_wr_data,
  dfls_char_if.sink                  char_ch,
  dfls_result_if.source              result_ch
);

  logic [WIDTH_BITS-1:0] max_width;

  // Input register
  logic       in_vld;
  logic [7:0] in_char;
  logic       in_eoi;

  // Scan state
  scan_ctl_t             ctl;
  logic [ACC_BITS-1:0]   int_acc;
  logic [ACC_BITS-1:0]   frac_acc;
  logic [ACC_BITS-1:0]   exp_acc;
  logic [COUNT_BITS-1:0] frac_count;
  logic [WIDTH_BITS-1:0] char_count;

  scan_ctl_t             ctl_next;
  logic [ACC_BITS-1:0]   int_acc_next;
  logic [ACC_BITS-1:0]   frac_acc_next;
  logic [ACC_BITS-1:0]   exp_acc_next;
  logic [COUNT_BITS-1:0] frac_count_next;
  logic [WIDTH_BITS-1:0] char_count_next;

  // Step outputs
  logic                  emit;
  res_flags_t            step_flags;
  logic [ACC_BITS-1:0]   step_int;
  logic [ACC_BITS-1:0]   step_frac;
  logic [COUNT_BITS-1:0] step_flen;
  logic [ACC_BITS-1:0]   step_exp;

  // Result register
  logic                  res_vld;
  res_flags_t            res_flags;
  logic [ACC_BITS-1:0]   res_int;
  logic [ACC_BITS-1:0]   res_frac;
  logic [COUNT_BITS-1:0] res_flen;
  logic [ACC_BITS-1:0]   res_exp;

  logic proceed;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= '0;
    end else if (cfg_wr_en) begin
      max_width <= cfg_wr_data;
    end
  end

  // The held character advances unless it makes a result and the result slot is stalled
  assign proceed       = in_vld && (!emit || !res_vld || result_ch.ready);
  assign char_ch.ready = !in_vld || proceed;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_ch.ready) begin
      in_vld <= char_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ch.valid && char_ch.ready) begin
      in_char <= char_ch.char_code;
      in_eoi  <= char_ch.end_of_input;
    end
  end

  dfls_step #(.ACC_BITS(ACC_BITS), .COUNT_BITS(COUNT_BITS)) u_step (
    .max_width       (max_width),
    .char_code       (in_char),
    .end_of_input    (in_eoi),
    .ctl             (ctl),
    .int_acc         (int_acc),
    .frac_acc        (frac_acc),
    .exp_acc         (exp_acc),
    .frac_count      (frac_count),
    .char_count      (char_count),
    .ctl_next        (ctl_next),
    .int_acc_next    (int_acc_next),
    .frac_acc_next   (frac_acc_next),
    .exp_acc_next    (exp_acc_next),
    .frac_count_next (frac_count_next),
    .char_count_next (char_count_next),
    .emit            (emit),
    .res_flags       (step_flags),
    .res_int         (step_int),
    .res_frac        (step_frac),
    .res_flen        (step_flen),
    .res_exp         (step_exp)
  );

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= SCAN_CTL_CLEAR;
      int_acc    <= '0;
      frac_acc   <= '0;
      exp_acc    <= '0;
      frac_count <= '0;
      char_count <= '0;
    end else if (proceed) begin
      ctl        <= ctl_next;
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      exp_acc    <= exp_acc_next;
      frac_count <= frac_count_next;
      char_count <= char_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (proceed && emit) begin
      res_vld <= 1'b1;
    end else if (result_ch.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emit) begin
      res_flags <= step_flags;
      res_int   <= step_int;
      res_frac  <= step_frac;
      res_flen  <= step_flen;
      res_exp   <= step_exp;
    end
  end

  assign result_ch.valid             = res_vld;
  assign result_ch.is_valid          = res_flags.is_valid;
  assign result_ch.char_taken        = res_flags.char_taken;
  assign result_ch.mantissa_negative = res_flags.mantissa_negative;
  assign result_ch.int_part          = res_int;
  assign result_ch.frac_digits       = res_frac;
  assign result_ch.frac_len          = res_flen;
  assign result_ch.exp_value         = res_exp;
  assign result_ch.exp_negative      = res_flags.exp_negative;
  assign result_ch.overflowed        = res_flags.overflowed;

endmodule

`default_nettype wire

/* hdl/dfls_checker.sv */
// Port-level assertions for the literal scanner, bound to the top level.
`default_nettype none

module dfls_checker import dfls_pkg::*; #(
  parameter int ACC_BITS   = ACC_BITS_DFLT,
  parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  char_ready,
  input wire logic                  result_valid,
  input wire logic                  result_ready,
  input wire logic                  is_valid,
  input wire logic                  char_taken,
  input wire logic                  mantissa_negative,
  input wire logic [ACC_BITS-1:0]   int_part,
  input wire logic [ACC_BITS-1:0]   frac_digits,
  input wire logic [COUNT_BITS-1:0] frac_len,
  input wire logic [ACC_BITS-1:0]   exp_value,
  input wire logic                  exp_negative,
  input wire logic                  overflowed
);

  // A pending result stays until its transfer
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(is_valid) && $stable(char_taken) && $stable(mantissa_negative) &&
      $stable(int_part) && $stable(frac_digits) && $stable(frac_len) &&
      $stable(exp_value) && $stable(exp_negative) && $stable(overflowed))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result pending right after reset");

  // With the result slot empty, the character side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> char_ready)
    else $error("character side stalled with empty result slot");

endmodule

bind decimal_float_literal_scanner dfls_checker #(
  .ACC_BITS   (ACC_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_dfls_checker (
  .clk               (clk),
  .rst               (rst),
  .char_ready        (char_ch.ready),
  .result_valid      (result_ch.valid),
  .result_ready      (result_ch.ready),
  .is_valid          (result_ch.is_valid),
  .char_taken        (result_ch.char_taken),
  .mantissa_negative (result_ch.mantissa_negative),
  .int_part          (result_ch.int_part),
  .frac_digits       (result_ch.frac_digits),
  .frac_len          (result_ch.frac_len),
  .exp_value         (result_ch.exp_value),
  .exp_negative      (result_ch.exp_negative),
  .overflowed        (result_ch.overflowed)
);

`default_nettype wire
